// File: design/mar_pkg.sv
package mar_pkg;

  localparam int INTERVAL_W = 24;
  localparam int RATE_W     = 32;

  // Microseconds per second times sixteen, for a result with four fraction bits.
  localparam longint unsigned RATE_SCALE = 64'd16000000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } mar_state_t;

endpackage

// File: design/mar_ram.sv
module mar_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/moving_average_rate_meter.sv
// Flow: a nonzero interval goes from acceptance through ST_READ and ST_DIV, where the
// bit-serial restoring divider works through the NUM_W bits of 16000000 * SAMPLE_COUNT
// (28 bits at the default), to ST_DONE; a zero interval goes straight to ST_DONE.
// ST_DONE loads the output register once it is free; no new input is taken until idle.
// Reset: synchronous, active high; the window reads as all zero until each slot is written.
module moving_average_rate_meter #(
  parameter int SAMPLE_COUNT = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mar_pkg::INTERVAL_W-1:0]    frame_interval,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mar_pkg::RATE_W-1:0]        rate_q4,
  output logic                              updated
);

  import mar_pkg::*;

  localparam int SLOT_W = $clog2(SAMPLE_COUNT);
  localparam int SUM_W  = INTERVAL_W + $clog2(SAMPLE_COUNT);
  localparam longint unsigned NUMERATOR = RATE_SCALE * 64'(SAMPLE_COUNT);
  localparam int NUM_W  = $clog2(NUMERATOR + 64'd1);
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam longint unsigned PSUM_MAX =
    64'(SAMPLE_COUNT - 1) * ((64'd1 << INTERVAL_W) - 64'd1);

  mar_state_t state, state_next;

  logic [SLOT_W-1:0]     slot;
  logic [SLOT_W-1:0]     slot_next;
  logic                  wrapped;
  logic                  old_valid;
  logic                  is_zero;
  logic [SUM_W-1:0]      psum;
  logic [SUM_W-1:0]      total;
  logic [SUM_W-1:0]      rem;
  logic [SUM_W-1:0]      rem_next;
  logic [SUM_W:0]        rem_trial;
  logic                  fits;
  logic [NUM_W-1:0]      num_sh;
  logic [RATE_W-1:0]     quo;
  logic                  sat;
  logic [CNT_W-1:0]      cnt;
  logic [INTERVAL_W-1:0] old_interval;
  logic                  accept;
  logic                  take_nonzero;
  logic                  out_load;

  assign accept       = in_valid && in_ready;
  assign take_nonzero = accept && (frame_interval != '0);
  assign slot_next    = (slot == SLOT_W'(SAMPLE_COUNT - 1)) ? '0 : slot + 1'b1;

  // The ring is written in slot order, so an entry ahead of the write slot holds data
  // only once the slot has wrapped; before that old_valid masks it out as zero.
  mar_ram #(
    .WIDTH (INTERVAL_W),
    .DEPTH (SAMPLE_COUNT)
  ) u_ring (
    .clk   (clk),
    .we    (take_nonzero),
    .waddr (slot),
    .wdata (frame_interval),
    .raddr (slot_next),
    .rdata (old_interval)
  );

  // One quotient bit per cycle: bring down a numerator bit and try a subtraction.
  assign rem_trial = {rem, num_sh[NUM_W-1]};
  assign fits      = rem_trial >= {1'b0, total};
  always_comb begin
    if (fits) begin
      rem_next = SUM_W'(rem_trial - {1'b0, total});
    end else begin
      rem_next = rem_trial[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (frame_interval == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == CNT_W'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      wrapped <= 1'b0;
      psum    <= '0;
    end else begin
      if (take_nonzero) begin
        slot <= slot_next;
        if (slot == SLOT_W'(SAMPLE_COUNT - 1)) begin
          wrapped <= 1'b1;
        end
      end
      if (state == ST_READ) begin
        psum <= total - (old_valid ? SUM_W'(old_interval) : '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_zero   <= (frame_interval == '0);
      total     <= psum + SUM_W'(frame_interval);
      old_valid <= wrapped || (slot == SLOT_W'(SAMPLE_COUNT - 1));
    end
    if (state == ST_READ) begin
      rem    <= '0;
      num_sh <= NUM_W'(NUMERATOR);
      quo    <= '0;
      sat    <= 1'b0;
      cnt    <= CNT_W'(NUM_W);
    end else if (state == ST_DIV) begin
      rem    <= rem_next;
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      quo    <= {quo[RATE_W-2:0], fits};
      sat    <= sat | quo[RATE_W-1];
      cnt    <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (is_zero) begin
        rate_q4 <= '0;
        updated <= 1'b0;
      end else begin
        rate_q4 <= sat ? '1 : quo;
        updated <= 1'b1;
      end
    end
  end

  a_zero_keeps_window: assert property (@(posedge clk) disable iff (rst)
    accept && (frame_interval == '0) |=> $stable(psum) && $stable(slot))
    else $error("zero interval changed the window");

  a_psum_bound: assert property (@(posedge clk) disable iff (rst)
    64'(psum) <= PSUM_MAX)
    else $error("partial sum exceeds the window bound");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < total)
    else $error("divider remainder not below divisor");

  a_skip_gives_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !updated |-> rate_q4 == '0)
    else $error("skipped beat carries a nonzero rate");

endmodule

// File: tb/rate_meter_checker.sv
`timescale 1ns / 100ps

module rate_meter_checker #(
  parameter int WINDOW = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [mar_pkg::INTERVAL_W-1:0]  frame_interval,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [mar_pkg::RATE_W-1:0]      rate_q4,
  input  logic                            updated,
  output int unsigned                     mismatches,
  output int unsigned                     awaiting,
  output int unsigned                     results_seen
);
  import mar_pkg::*;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              updated;
  } rate_beat_t;

  localparam longint unsigned RATE_NUM  = RATE_SCALE * longint'(WINDOW);
  localparam longint unsigned RATE_CEIL = (64'd1 << RATE_W) - 64'd1;
  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int PEND_DEPTH = 8;
  localparam int PEND_W     = $clog2(PEND_DEPTH);

  logic [INTERVAL_W-1:0] window_ring [WINDOW];
  logic [SLOT_W-1:0]     oldest_slot;
  longint unsigned       newest_sum;
  rate_beat_t            pending [PEND_DEPTH];
  logic [PEND_W-1:0]     pend_head;
  logic [PEND_W-1:0]     pend_tail;
  int unsigned           pend_count;
  rate_beat_t            predicted;
  rate_beat_t            oldest;

  // The sum leaves out the oldest entry, so the next interval completes the window.
  function automatic rate_beat_t predict_rate(logic [INTERVAL_W-1:0] interval);
    rate_beat_t      r;
    longint unsigned total;
    longint unsigned quotient;
    if (interval == '0) begin
      r.rate    = '0;
      r.updated = 1'b0;
      return r;
    end
    total    = newest_sum + longint'(interval);
    quotient = RATE_NUM / total;
    if (quotient > RATE_CEIL)
      quotient = RATE_CEIL;
    window_ring[oldest_slot] = interval;
    oldest_slot = (oldest_slot == SLOT_W'(WINDOW - 1)) ? '0 : oldest_slot + 1'b1;
    newest_sum  = total - longint'(window_ring[oldest_slot]);
    r.rate    = quotient[RATE_W-1:0];
    r.updated = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (window_ring[i])
        window_ring[i] = '0;
      oldest_slot  = '0;
      newest_sum   = 0;
      mismatches   = 0;
      results_seen = 0;
      pend_head    = '0;
      pend_tail    = '0;
      pend_count   = 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = predict_rate(frame_interval);
        if (pend_count == PEND_DEPTH) begin
          report_mismatch("outstanding input beats", 64'(PEND_DEPTH), 64'(pend_count + 1));
        end else begin
          pending[pend_tail] = predicted;
          pend_tail = pend_tail + 1'b1;
          pend_count++;
        end
      end
      if (out_valid && out_ready) begin
        if (pend_count == 0) begin
          report_mismatch("result beat with nothing outstanding, rate_q4", 64'd0,
                          64'(rate_q4));
        end else begin
          oldest    = pending[pend_head];
          pend_head = pend_head + 1'b1;
          pend_count--;
          if (rate_q4 !== oldest.rate)
            report_mismatch("rate_q4", 64'(oldest.rate), 64'(rate_q4));
          if (updated !== oldest.updated)
            report_mismatch("updated", 64'(oldest.updated), 64'(updated));
          results_seen++;
        end
      end
    end
    awaiting = pend_count;
  end

endmodule

// File: tb/moving_average_rate_meter_test.sv
`timescale 1ns / 100ps

module moving_average_rate_meter_test;
  import mar_pkg::*;

  localparam int WINDOW      = 16;
  localparam int PHASE_BEATS = 442;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 40;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [INTERVAL_W-1:0] frame_interval;
  logic                  out_valid;
  logic                  out_ready;
  logic [RATE_W-1:0]     rate_q4;
  logic                  updated;

  int unsigned mismatches;
  int unsigned awaiting;
  int unsigned results_seen;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned zero_beats;
  int unsigned live_beats;
  bit          hold_request;

  logic [INTERVAL_W-1:0] corner_intervals [9] = '{
    24'd0, 24'd1, 24'hFFFFFF, 24'd0, 24'hAAAAAA, 24'h555555, 24'h800000, 24'd16667, 24'd0
  };

  moving_average_rate_meter #(
    .SAMPLE_COUNT(WINDOW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .frame_interval(frame_interval),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rate_q4(rate_q4),
    .updated(updated)
  );

  rate_meter_checker #(
    .WINDOW(WINDOW)
  ) rate_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .frame_interval(frame_interval),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rate_q4(rate_q4),
    .updated(updated),
    .mismatches(mismatches),
    .awaiting(awaiting),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

  // Output side: random back-pressure, plus one long hold-off on request so that the
  // block fills up and refuses further input beats.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Plausible frame times, mixed with short, huge, full-range and unmeasured ones.
  function automatic logic [INTERVAL_W-1:0] pick_interval();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return INTERVAL_W'($urandom_range(255, 1));
      3, 4, 5: return INTERVAL_W'($urandom_range(50000, 4000));
      6, 7:    return INTERVAL_W'($urandom);
      default: return INTERVAL_W'($urandom_range(16777215, 16000000));
    endcase
  endfunction

  task automatic send_interval(logic [INTERVAL_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    frame_interval <= value;
    do
      @(posedge clk);
    while (!in_ready);
    if (value == '0)
      zero_beats++;
    else
      live_beats++;
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    frame_interval = '0;
    hold_request   = 1'b0;
    tx_idle_pct    = 11;
    rx_idle_pct    = 73;
    zero_beats     = 0;
    live_beats     = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (corner_intervals[i])
      send_interval(corner_intervals[i]);
    // Sixteen maximum intervals fill the whole window and wrap the write slot.
    repeat (WINDOW) send_interval('1);

    repeat (PHASE_BEATS) send_interval(pick_interval());
    tx_idle_pct = 73;
    rx_idle_pct = 11;
    repeat (PHASE_BEATS) send_interval(pick_interval());
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_request = 1'b1;
    repeat (PHASE_BEATS) send_interval(pick_interval());
    in_valid <= 1'b0;

    for (int n = 0; n < DRAIN_LIMIT && awaiting != 0; n++)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d interval beats (%0d unmeasured) and checked %0d rate results,",
             zero_beats + live_beats, zero_beats, results_seen);
    $display("under three idling mixes and one long output hold-off.");
    if (mismatches == 0 && awaiting == 0) begin
      $display("All tests passed");
    end else begin
      if (awaiting != 0)
        $display("%0d expected results never arrived", awaiting);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
